/* hdl/vca_pkg.sv */
package vca_pkg;

    localparam int unsigned NUM_CHANNELS = 16;
    localparam int unsigned TONE_FIRST   = 8;
    localparam int unsigned NOISE_FIRST  = 14;

    localparam int unsigned IDX_W    = $clog2(NUM_CHANNELS);
    localparam int unsigned BND_W    = $clog2(NUM_CHANNELS + 1);
    localparam int unsigned LEVEL_W  = 20;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned CLASS_W  = 2;
    localparam int unsigned CHAN_W   = 4;

    // Search bounds clipped to the table
    localparam int unsigned TONE_LO  = (TONE_FIRST > NUM_CHANNELS) ? NUM_CHANNELS : TONE_FIRST;
    localparam int unsigned NOISE_LO = (NOISE_FIRST > NUM_CHANNELS) ? NUM_CHANNELS : NOISE_FIRST;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ALLOC  = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_START   = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_RELEASE = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_ANY   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_TONE  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NOISE = 2'd2;

    // Entry write broadcast to every cell
    typedef struct packed {
        logic                      we;
        logic [IDX_W-1:0]          idx;
        logic                      active;
        logic [PHASE_W-1:0]        phase;
        logic signed [LEVEL_W-1:0] level;
        logic [PRIO_W-1:0]         prio;
    } upd_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                      vld;
        logic [BND_W-1:0]          lo;
        logic [BND_W-1:0]          hi;
        logic [PRIO_W-1:0]         want;
        logic                      free_hit;
        logic [IDX_W-1:0]          free_idx;
        logic                      rel_hit;
        logic signed [LEVEL_W-1:0] rel_level;
        logic [IDX_W-1:0]          rel_idx;
        logic                      low_hit;
        logic [IDX_W-1:0]          low_idx;
    } token_t;

endpackage

/* hdl/vca_cell.sv */
module vca_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [vca_pkg::IDX_W-1:0]   cell_idx,
    input  vca_pkg::upd_t               upd,
    input  vca_pkg::token_t             tok_in,
    output vca_pkg::token_t             tok_out
);

    logic                               active_reg;
    logic [vca_pkg::PHASE_W-1:0]        phase_reg;
    logic signed [vca_pkg::LEVEL_W-1:0] level_reg;
    logic [vca_pkg::PRIO_W-1:0]         prio_reg;

    vca_pkg::token_t tok_reg;
    vca_pkg::token_t tok_next;

    logic in_range;
    logic is_free;
    logic is_rel;
    logic is_low;

    assign in_range = (vca_pkg::BND_W'(cell_idx) >= tok_in.lo) &&
                      (vca_pkg::BND_W'(cell_idx) < tok_in.hi);
    assign is_free  = !active_reg && (phase_reg != vca_pkg::PHASE_START);
    assign is_rel   = (phase_reg == vca_pkg::PHASE_RELEASE) && (level_reg < tok_in.rel_level);
    assign is_low   = prio_reg < tok_in.want;

    always_comb begin
        tok_next = tok_in;
        if (in_range) begin
            if (is_free && !tok_in.free_hit) begin
                tok_next.free_hit = 1'b1;
                tok_next.free_idx = cell_idx;
            end
            // strict compare keeps the lower index on ties
            if (is_rel) begin
                tok_next.rel_hit   = 1'b1;
                tok_next.rel_level = level_reg;
                tok_next.rel_idx   = cell_idx;
            end
            if (is_low && !tok_in.low_hit) begin
                tok_next.low_hit = 1'b1;
                tok_next.low_idx = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            phase_reg   <= '0;
            level_reg   <= '0;
            prio_reg    <= '0;
            tok_reg.vld <= 1'b0;
        end else begin
            if (upd.we && (upd.idx == cell_idx)) begin
                active_reg <= upd.active;
                phase_reg  <= upd.phase;
                level_reg  <= upd.level;
                prio_reg   <= upd.prio;
            end
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hdl/voice_channel_allocator_unit.sv */
// Update transfer: written into the channel entry in the cycle after acceptance, 1 per cycle while s_tready is high.
// Allocate transfer: a search token walks the row of NUM_CHANNELS cells, one cell per
// cycle; the result is then held in pend_*_reg and loaded into the output register.
// One allocation is in flight at a time: s_tready stays low until the held result moves on.
// Reset (aresetn low, synchronous) clears every channel entry to zero and empties the
// search row and the output register.
module voice_channel_allocator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // chan_index[3:0], chan_active[4], env_phase[6:5], chan_level[26:7],
    // chan_prio[34:27], want_prio[42:35], voice_class[44:43], zero[47:45]
    input  logic [47:0] s_tdata,
    // op[0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // granted[0], chosen[4:1], zero[7:5]
    output logic [7:0]  m_tdata
);

    localparam int unsigned N = vca_pkg::NUM_CHANNELS;

    logic [vca_pkg::CHAN_W-1:0]         in_chan;
    logic                               in_active;
    logic [vca_pkg::PHASE_W-1:0]        in_phase;
    logic signed [vca_pkg::LEVEL_W-1:0] in_level;
    logic [vca_pkg::PRIO_W-1:0]         in_prio;
    logic [vca_pkg::PRIO_W-1:0]         in_want;
    logic [vca_pkg::CLASS_W-1:0]        in_class;

    logic s_xfer;
    logic alloc_xfer;

    logic scan_busy_reg;
    logic pend_valid_reg;
    logic pend_granted_reg;
    logic [vca_pkg::CHAN_W-1:0] pend_chosen_reg;
    logic m_valid_reg;
    logic m_granted_reg;
    logic [vca_pkg::CHAN_W-1:0] m_chosen_reg;

    vca_pkg::upd_t   upd;
    vca_pkg::token_t tok [0:N];

    logic                     tail_granted;
    logic [vca_pkg::IDX_W-1:0] tail_idx;

    assign in_chan   = s_tdata[3:0];
    assign in_active = s_tdata[4];
    assign in_phase  = s_tdata[6:5];
    assign in_level  = s_tdata[26:7];
    assign in_prio   = s_tdata[34:27];
    assign in_want   = s_tdata[42:35];
    assign in_class  = s_tdata[44:43];

    assign s_tready   = !scan_busy_reg && !pend_valid_reg;
    assign s_xfer     = s_tvalid && s_tready;
    assign alloc_xfer = s_xfer && (s_tuser[0] == vca_pkg::OP_ALLOC);

    // Drop updates that point past the table
    always_comb begin
        upd.we     = s_xfer && (s_tuser[0] == vca_pkg::OP_UPDATE) &&
                     (32'(in_chan) < N);
        upd.idx    = vca_pkg::IDX_W'(in_chan);
        upd.active = in_active;
        upd.phase  = in_phase;
        upd.level  = in_level;
        upd.prio   = in_prio;
    end

    // Launch token for the first cell
    always_comb begin
        tok[0]           = '0;
        tok[0].vld       = alloc_xfer;
        tok[0].want      = in_want;
        tok[0].rel_level = vca_pkg::LEVEL_W'(1);
        case (in_class)
            vca_pkg::CLASS_ANY: begin
                tok[0].lo = '0;
                tok[0].hi = vca_pkg::BND_W'(N);
            end
            vca_pkg::CLASS_TONE: begin
                tok[0].lo = vca_pkg::BND_W'(vca_pkg::TONE_LO);
                tok[0].hi = vca_pkg::BND_W'(vca_pkg::NOISE_LO);
            end
            vca_pkg::CLASS_NOISE: begin
                tok[0].lo = vca_pkg::BND_W'(vca_pkg::NOISE_LO);
                tok[0].hi = vca_pkg::BND_W'(N);
            end
            default: begin
                tok[0].lo = '0;
                tok[0].hi = '0;
            end
        endcase
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        vca_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (vca_pkg::IDX_W'(g)),
            .upd      (upd),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1])
        );
    end

    // Free channel first, then quietest release, then lower priority
    always_comb begin
        tail_granted = tok[N].free_hit || tok[N].rel_hit || tok[N].low_hit;
        if (tok[N].free_hit) begin
            tail_idx = tok[N].free_idx;
        end else if (tok[N].rel_hit) begin
            tail_idx = tok[N].rel_idx;
        end else if (tok[N].low_hit) begin
            tail_idx = tok[N].low_idx;
        end else begin
            tail_idx = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_busy_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (alloc_xfer) begin
                scan_busy_reg <= 1'b1;
            end else if (tok[N].vld) begin
                scan_busy_reg <= 1'b0;
            end
            if (tok[N].vld) begin
                pend_valid_reg   <= 1'b1;
                pend_granted_reg <= tail_granted;
                pend_chosen_reg  <= vca_pkg::CHAN_W'(tail_idx);
            end else if (pend_valid_reg && (!m_valid_reg || m_tready)) begin
                pend_valid_reg <= 1'b0;
            end
            // advance the held result into the output register
            if (pend_valid_reg && (!m_valid_reg || m_tready)) begin
                m_valid_reg   <= 1'b1;
                m_granted_reg <= pend_granted_reg;
                m_chosen_reg  <= pend_chosen_reg;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_chosen_reg, m_granted_reg};

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(scan_busy_reg && pend_valid_reg))
        else $error("search and held result overlap");

    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[N].vld |-> scan_busy_reg)
        else $error("token left the row with no search running");

    a_alloc_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_xfer |=> scan_busy_reg && !s_tready)
        else $error("allocate transfer did not start a search");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[N].vld |=> pend_valid_reg && !scan_busy_reg)
        else $error("search result not held");

endmodule
